/* design/stop_and_wait_frame_sender_assert.svh */
// ----------------------------------------------------------------------------
// Stop-and-wait frame sender assertion macros
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_FRAME_SENDER_ASSERT_SVH
`define STOP_AND_WAIT_FRAME_SENDER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SWFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swfs assertion failed");

// next-cycle implication
`define SWFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swfs assertion failed");

`else

`define SWFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define SWFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/swfs_pkg.sv */
// ----------------------------------------------------------------------------
// swfs_pkg
// Shared constants and types of the stop-and-wait frame sender.
// ----------------------------------------------------------------------------
package swfs_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHUNK_BYTES = 8;                  // data bytes per frame
    localparam int INPUT_BYTES = 8;                  // bytes carried by chunk_data
    localparam int FRAME_BYTES = CHUNK_BYTES + 2;    // data, check, sequence
    localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
    localparam int CHUNK_W     = CHUNK_BYTES * BYTE_W;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] ASCII_ONE  = 8'd49;

    typedef enum logic
    {
        FUNC_CHUNK = 1'b0,
        FUNC_ACK   = 1'b1
    } func_t;

    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed
    {
        logic   load;
        frame_t frame;
    } ser_ctrl_t;

    typedef struct packed
    {
        logic can_load;
    } ser_stat_t;

endpackage

/* design/swfs_chunk_if.sv */
// ----------------------------------------------------------------------------
// swfs_chunk_if
// Input channel: new chunk or acknowledgement, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swfs_chunk_if;

    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] chunk_data;
    logic [7:0]  ack_status;

    modport source
    (
        output valid,
        input  ready,
        output func,
        output chunk_data,
        output ack_status
    );

    modport sink
    (
        input  valid,
        output ready,
        input  func,
        input  chunk_data,
        input  ack_status
    );

endinterface

/* design/swfs_frame_if.sv */
// ----------------------------------------------------------------------------
// swfs_frame_if
// Output channel: one frame byte per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swfs_frame_if;

    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source
    (
        output valid,
        input  ready,
        output frame_byte,
        output frame_end
    );

    modport sink
    (
        input  valid,
        output ready,
        input  frame_byte,
        input  frame_end
    );

endinterface

/* design/stop_and_wait_frame_sender.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_frame_sender
// Sender side of a stop-and-wait link: builds and resends 10-byte frames.
// ----------------------------------------------------------------------------
// Flow: an item is held in the input register until its frame is loaded
//   into the serializer buffer, from which the frame bytes are offered.
// Throughput: one frame byte per cycle while the output is ready, set by
//   the byte-wide output of the serializer; an ack that asks for no resend
//   leaves the input register without loading a frame.
// Reset: asynchronous, clears the input and output stages; stored data and
//   check read as zero and the sequence bit as one until the first chunk.
`include "stop_and_wait_frame_sender_assert.svh"

module stop_and_wait_frame_sender
(
    input  logic         clk,
    input  logic         rst_n,
    swfs_chunk_if.sink   chunk,
    swfs_frame_if.source frame
);

    // ------------------------------------------------------------------
    // input register: holds one item until its frame can be loaded
    // ------------------------------------------------------------------
    logic                           item_valid_reg;
    swfs_pkg::func_t                func_reg;
    logic [63:0]                    data_reg;
    logic [7:0]                     status_reg;

    // link state
    logic [swfs_pkg::CHUNK_W-1:0]   store_reg;
    logic [swfs_pkg::BYTE_W-1:0]    check_reg;
    logic                           seq_reg;

    logic [swfs_pkg::CHUNK_W-1:0]   store_next;
    logic [swfs_pkg::BYTE_W-1:0]    check_next;
    logic                           seq_next;

    logic [swfs_pkg::CHUNK_BYTES-1:0] hit;
    logic                           is_chunk;
    logic                           needs_frame;
    logic                           item_done;
    logic                           chunk_take;

    swfs_pkg::ser_ctrl_t            ser_ctrl;
    swfs_pkg::ser_stat_t            ser_stat;

    assign is_chunk    = (func_reg == swfs_pkg::FUNC_CHUNK);
    assign needs_frame = is_chunk || (status_reg == swfs_pkg::ASCII_ZERO);

    // an item leaves the input register when its frame goes to the
    // serializer, or at once if it is an ack that asks for nothing
    assign item_done   = item_valid_reg && (!needs_frame || ser_stat.can_load);
    assign chunk.ready = !item_valid_reg || item_done;
    assign chunk_take  = chunk.valid && chunk.ready;

    // ------------------------------------------------------------------
    // chunk bytes: bytes past what chunk_data carries are stored as zero
    // ------------------------------------------------------------------
    for (genvar k = 0; k < swfs_pkg::CHUNK_BYTES; k++)
    begin : g_byte
        if (k < swfs_pkg::INPUT_BYTES)
        begin : g_data
            assign store_next[k*swfs_pkg::BYTE_W +: swfs_pkg::BYTE_W] =
                data_reg[k*swfs_pkg::BYTE_W +: swfs_pkg::BYTE_W];
        end
        else
        begin : g_zero
            assign store_next[k*swfs_pkg::BYTE_W +: swfs_pkg::BYTE_W] = '0;
        end
        assign hit[k] =
            (store_next[k*swfs_pkg::BYTE_W +: swfs_pkg::BYTE_W] == swfs_pkg::ASCII_ONE);
    end

    // check char: '1' on an odd count of '1' bytes
    assign check_next = (^hit) ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO;
    assign seq_next   = ~seq_reg;

    // ------------------------------------------------------------------
    // frame build: byte 0 goes out first, sequence char last
    // ------------------------------------------------------------------
    always_comb
    begin
        ser_ctrl.load = item_done && needs_frame;
        if (is_chunk)
        begin
            ser_ctrl.frame = {(seq_next ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO),
                              check_next, store_next};
        end
        else
        begin
            ser_ctrl.frame = {(seq_reg ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO),
                              check_reg, store_reg};
        end
    end

    swfs_serializer u_serializer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ser_ctrl),
        .stat  (ser_stat),
        .frame (frame)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            store_reg      <= '0;
            check_reg      <= '0;
            seq_reg        <= 1'b1;
        end
        else
        begin
            if (chunk_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end

            // a new chunk updates the link state as its frame is loaded
            if (item_done && is_chunk)
            begin
                store_reg <= store_next;
                check_reg <= check_next;
                seq_reg   <= seq_next;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (chunk_take)
        begin
            func_reg   <= swfs_pkg::func_t'(chunk.func);
            data_reg   <= chunk.chunk_data;
            status_reg <= chunk.ack_status;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SWFS_ASSERT_SAME(a_no_frame_on_plain_ack, clk, rst_n,
        item_valid_reg && !is_chunk && (status_reg != swfs_pkg::ASCII_ZERO),
        !ser_ctrl.load && item_done)
    `SWFS_ASSERT_NEXT(a_chunk_toggles_seq, clk, rst_n,
        item_done && is_chunk, seq_reg != $past(seq_reg))
    `SWFS_ASSERT_NEXT(a_ack_keeps_state, clk, rst_n,
        item_done && !is_chunk, $stable(seq_reg) && $stable(check_reg))
    `SWFS_ASSERT_SAME(a_last_byte_is_seq_char, clk, rst_n,
        frame.valid && frame.frame_end,
        (frame.frame_byte == swfs_pkg::ASCII_ZERO) || (frame.frame_byte == swfs_pkg::ASCII_ONE))

endmodule

/* design/swfs_serializer.sv */
// ----------------------------------------------------------------------------
// swfs_serializer
// Holds one built frame and shifts it out a byte per transfer.
// ----------------------------------------------------------------------------
module swfs_serializer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swfs_pkg::ser_ctrl_t  ctrl,
    output swfs_pkg::ser_stat_t  stat,
    swfs_frame_if.source         frame
);

    swfs_pkg::frame_t                buf_reg;
    swfs_pkg::frame_t                buf_next;
    logic [swfs_pkg::CNT_W-1:0]      cnt_reg;
    logic [swfs_pkg::CNT_W-1:0]      cnt_next;
    logic                            take;
    logic                            last;

    assign take = frame.valid && frame.ready;
    assign last = (cnt_reg == swfs_pkg::CNT_W'(1));

    assign frame.valid      = (cnt_reg != '0);
    assign frame.frame_byte = buf_reg[swfs_pkg::BYTE_W-1:0];
    assign frame.frame_end  = last;

    // a new frame may enter while the last byte of the old one leaves
    assign stat.can_load = (cnt_reg == '0) || (take && last);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            buf_next = ctrl.frame;
            cnt_next = swfs_pkg::CNT_W'(swfs_pkg::FRAME_BYTES);
        end
        else if (take)
        begin
            buf_next = buf_reg >> swfs_pkg::BYTE_W;
            cnt_next = cnt_reg - swfs_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stop_and_wait_frame_sender. Chunks and
// acknowledgements go in on the input channel. Each one is predicted into a
// queue of expected frame bytes. Every byte transfer on the output channel is
// compared with the head of that queue. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    // one expected byte of a frame
    typedef struct packed
    {
        logic [swfs_pkg::BYTE_W-1:0] value;
        logic                        last;
    } frame_beat_t;

    // ------------------------------------------------------------------------
    // Frame tracker: mirrors the sender's stored frame and holds the bytes
    // still owed on the output channel.
    // ------------------------------------------------------------------------
    class frame_tracker_t;

        logic [swfs_pkg::BYTE_W-1:0] data_bytes [swfs_pkg::CHUNK_BYTES];
        logic [swfs_pkg::BYTE_W-1:0] check_char;
        logic                        seq_bit;
        frame_beat_t                 owed_bytes [$];
        int                          failures;

        // state after reset: zero data, zero check byte (not '0'), sequence one
        function new();
            foreach (data_bytes[k])
                data_bytes[k] = '0;
            check_char = '0;
            seq_bit    = 1'b1;
            failures   = 0;
        endfunction

        // queue the stored frame: data, check char, sequence char
        function void queue_frame();
            frame_beat_t beat;
            for (int k = 0; k < swfs_pkg::CHUNK_BYTES; k++)
            begin
                beat.value = data_bytes[k];
                beat.last  = 1'b0;
                owed_bytes.push_back(beat);
            end
            beat.value = check_char;
            beat.last  = 1'b0;
            owed_bytes.push_back(beat);
            beat.value = seq_bit ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO;
            beat.last  = 1'b1;
            owed_bytes.push_back(beat);
        endfunction

        // called on every accepted input transfer
        function void take_item(swfs_pkg::func_t f, logic [63:0] d, logic [7:0] s);
            logic odd_ones;
            if (f == swfs_pkg::FUNC_CHUNK)
            begin
                odd_ones = 1'b0;
                for (int k = 0; k < swfs_pkg::CHUNK_BYTES; k++)
                begin
                    // bytes beyond the input width are stored as zero
                    data_bytes[k] = (k < swfs_pkg::INPUT_BYTES) ? d[8*k +: 8] : '0;
                    if (data_bytes[k] == swfs_pkg::ASCII_ONE)
                        odd_ones = ~odd_ones;
                end
                check_char = odd_ones ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO;
                seq_bit    = ~seq_bit;
                queue_frame();
            end
            else if (s == swfs_pkg::ASCII_ZERO)
                queue_frame();
        endfunction

        // called on every accepted output transfer
        function void check_byte(logic [swfs_pkg::BYTE_W-1:0] value, logic last);
            frame_beat_t want;
            if (owed_bytes.size() == 0)
            begin
                $error("unexpected frame byte %0d (frame_end %0b)", value, last);
                failures++;
                return;
            end
            want = owed_bytes.pop_front();
            if (value !== want.value)
            begin
                $error("frame_byte mismatch: expected %0d, got %0d", want.value, value);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("frame_end mismatch: expected %0b, got %0b", want.last, last);
                failures++;
            end
        endfunction

        function int outstanding();
            return owed_bytes.size();
        endfunction

    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    swfs_chunk_if chunk_bus ();
    swfs_frame_if frame_bus ();

    stop_and_wait_frame_sender dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .chunk (chunk_bus),
        .frame (frame_bus)
    );

    frame_tracker_t tracker = new();

    // idling switches, changed per phase so that some stretches run flat out
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    // long receiver hold-off requested by the stimulus, served by the receiver
    int rx_hold_cycles = 0;

    // ------------------------------------------------------------------------
    // Sender: one input transfer. Entered just after a rising edge (or after
    // reset); fields change at the falling edge, ready is sampled at the
    // rising edge. Valid is only lowered when a gap is actually drawn, so a
    // back-to-back transfer keeps it high.
    // ------------------------------------------------------------------------
    task automatic send_item(swfs_pkg::func_t f, logic [63:0] d, logic [7:0] s);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            chunk_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        chunk_bus.valid      = 1'b1;
        chunk_bus.func       = f;
        chunk_bus.chunk_data = d;
        chunk_bus.ack_status = s;
        do
            @(posedge clk);
        while (chunk_bus.ready !== 1'b1);
        tracker.take_item(f, d, s);
    endtask

    // lower valid and wait until every owed byte has come out
    task automatic wait_drained();
        @(negedge clk);
        chunk_bus.valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: draws a stall per byte, serves a requested hold-off, checks
    // every byte transfer. Ready stays high across transfers when no stall
    // is drawn.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        frame_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                frame_bus.ready = 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            stall = rx_idle_on ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                frame_bus.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            frame_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (frame_bus.valid !== 1'b1);
            tracker.check_byte(frame_bus.frame_byte, frame_bus.frame_end);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [63:0]     word;
        logic [7:0]      status;
        swfs_pkg::func_t f;

        chunk_bus.valid      = 1'b0;
        chunk_bus.func       = swfs_pkg::FUNC_CHUNK;
        chunk_bus.chunk_data = '0;
        chunk_bus.ack_status = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed ---
        // resend before any chunk: reset frame, zero check byte, sequence '1'
        send_item(swfs_pkg::FUNC_ACK, {$urandom, $urandom}, swfs_pkg::ASCII_ZERO);
        // acks that ask for nothing, ignored data at its extremes
        send_item(swfs_pkg::FUNC_ACK, '1, 8'd0);
        send_item(swfs_pkg::FUNC_ACK, '0, 8'd255);
        send_item(swfs_pkg::FUNC_ACK, {$urandom, $urandom}, swfs_pkg::ASCII_ZERO - 8'd1);
        send_item(swfs_pkg::FUNC_ACK, {$urandom, $urandom}, swfs_pkg::ASCII_ONE);
        // first chunk, all zero; status '0' must be ignored on a chunk
        send_item(swfs_pkg::FUNC_CHUNK, '0, swfs_pkg::ASCII_ZERO);
        send_item(swfs_pkg::FUNC_ACK, '1, swfs_pkg::ASCII_ZERO);
        send_item(swfs_pkg::FUNC_CHUNK, '1, 8'd255);
        send_item(swfs_pkg::FUNC_ACK, '0, swfs_pkg::ASCII_ZERO);
        // 1..8 bytes equal to '1', rest '0': check char follows the parity
        for (int n = 1; n <= swfs_pkg::INPUT_BYTES; n++)
        begin
            word = '0;
            for (int k = 0; k < swfs_pkg::INPUT_BYTES; k++)
                word[8*k +: 8] = (k < n) ? swfs_pkg::ASCII_ONE : swfs_pkg::ASCII_ZERO;
            send_item(swfs_pkg::FUNC_CHUNK, word, 8'($urandom));
        end
        send_item(swfs_pkg::FUNC_ACK, '0, swfs_pkg::ASCII_ZERO);
        send_item(swfs_pkg::FUNC_ACK, '0, swfs_pkg::ASCII_ZERO);

        // --- random ---
        // Mostly chunk/ack exchanges with resend-heavy acks; data bytes are
        // biased towards '1' so both check characters turn up often.
        for (int i = 0; i < 140; i++)
        begin
            if (i % 20 == 0)
            begin
                tx_idle_on = $urandom_range(0, 3) != 0;
                rx_idle_on = $urandom_range(0, 3) != 0;
            end
            // block fills up behind a long receiver hold-off
            if (i == 50)
            begin
                tx_idle_on     = 1'b0;
                rx_hold_cycles = 150;
            end
            // sender pauses until the output has caught up
            if (i == 100)
                wait_drained();

            f = swfs_pkg::func_t'($urandom_range(0, 1));
            for (int k = 0; k < swfs_pkg::INPUT_BYTES; k++)
                word[8*k +: 8] = ($urandom_range(0, 9) < 4) ? swfs_pkg::ASCII_ONE
                                                             : 8'($urandom);
            status = ($urandom_range(0, 1) != 0) ? swfs_pkg::ASCII_ZERO : 8'($urandom);
            send_item(f, word, status);
        end

        // --- drain and report ---
        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.outstanding() != 0)
        begin
            $error("%0d frame bytes never arrived", tracker.outstanding());
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("stop_and_wait_frame_sender verification clean");
        else
            $display("stop_and_wait_frame_sender verification failed");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("stop_and_wait_frame_sender verification failed");
        $finish;
    end

endmodule

/* stop_and_wait_frame_sender.f */
+incdir+design
design/swfs_pkg.sv
design/swfs_chunk_if.sv
design/swfs_frame_if.sv
design/swfs_serializer.sv
design/stop_and_wait_frame_sender.sv
dv/testbench.sv
